FILE: design/edsw_pkg.sv
// ----------------------------------------------------------------------------
// edsw_pkg: shared types and constants for the 3x3 edge detector
// Beat structs passed between pipeline sections, register codes and the
// square-root digit step.
// ----------------------------------------------------------------------------
package edsw_pkg;

   localparam int NUM_TAPS    = 9;
   localparam int PIX_W       = 24;
   localparam int SMP_W       = 8;
   localparam int PADDR_W     = 3;
   localparam int SQRT_STAGES = 4;   // two root bits per stage
   localparam int PIPE_LATENCY = 9;  // start to rsp_strobe, in cycles

   // window taps, row-major, top row first
   localparam int TAP_NW  = 0;
   localparam int TAP_N   = 1;
   localparam int TAP_NE  = 2;
   localparam int TAP_W   = 3;
   localparam int TAP_CTR = 4;
   localparam int TAP_E   = 5;
   localparam int TAP_SW  = 6;
   localparam int TAP_S   = 7;
   localparam int TAP_SE  = 8;

   // channel_select codes
   localparam logic [1:0] CH_GREY  = 2'd0;
   localparam logic [1:0] CH_RED   = 2'd1;
   localparam logic [1:0] CH_GREEN = 2'd2;
   localparam logic [1:0] CH_BLUE  = 2'd3;

   // edge_operator codes
   localparam logic OP_SOBEL   = 1'b0;
   localparam logic OP_LAPLACE = 1'b1;

   // register word index (paddr[2])
   localparam logic REG_CHANNEL_SELECT = 1'b0;
   localparam logic REG_EDGE_OPERATOR  = 1'b1;

   // floor(x/3) for x <= 765 as (x*683) >> 11
   localparam logic [9:0] GREY_RECIP = 10'd683;

   typedef logic [NUM_TAPS-1:0][PIX_W-1:0] window_pix_type;

   typedef struct packed {
      logic                             valid;
      logic                             op;
      logic [NUM_TAPS-1:0][SMP_W-1:0]   smp;
   } window_beat_type;

   typedef struct packed {
      logic        valid;
      logic        op;
      logic        big;     // gradient sum >= 65536, root saturates
      logic [7:0]  lap;     // clamped Laplacian response
      logic [15:0] n;       // radicand bits not yet consumed, msb first
      logic [9:0]  rem;
      logic [7:0]  root;
   } sqrt_beat_type;

   // one restoring digit step of the integer square root
   function automatic sqrt_beat_type sqrt_step(sqrt_beat_type s);
      sqrt_beat_type r;
      logic [11:0]   cur_rem;
      logic [11:0]   trial;
      logic [11:0]   diff;
      r       = s;
      cur_rem = {s.rem, s.n[15:14]};
      trial   = {2'b00, s.root, 2'b01};
      diff    = cur_rem - trial;
      if (cur_rem >= trial) begin
         r.rem  = diff[9:0];
         r.root = {s.root[6:0], 1'b1};
      end else begin
         r.rem  = cur_rem[9:0];
         r.root = {s.root[6:0], 1'b0};
      end
      r.n = {s.n[13:0], 2'b00};
      return r;
   endfunction

endpackage

FILE: design/edsw_extract.sv
// ----------------------------------------------------------------------------
// edsw_extract: channel extraction, one lane per window tap
// Reduces each 0xRRGGBB pixel to one 8-bit sample, registered.
// ----------------------------------------------------------------------------
module edsw_extract (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [1:0]               channel_select,
   input  logic                     edge_operator,
   input  edsw_pkg::window_pix_type pix,
   output edsw_pkg::window_beat_type beat
);

   logic [edsw_pkg::NUM_TAPS-1:0][7:0]  smp_in;
   logic [edsw_pkg::NUM_TAPS-1:0][7:0]  smp_ff;
   logic [edsw_pkg::NUM_TAPS-1:0][9:0]  rgb_sum;
   logic [edsw_pkg::NUM_TAPS-1:0][19:0] grey_prod;
   logic                                valid_ff;
   logic                                op_ff;

   always_comb begin
      for (int i = 0; i < edsw_pkg::NUM_TAPS; i++) begin
         rgb_sum[i]   = {2'b00, pix[i][23:16]} + {2'b00, pix[i][15:8]}
                      + {2'b00, pix[i][7:0]};
         grey_prod[i] = {10'd0, rgb_sum[i]} * {10'd0, edsw_pkg::GREY_RECIP};
         case (channel_select)
            edsw_pkg::CH_RED:   smp_in[i] = pix[i][23:16];
            edsw_pkg::CH_GREEN: smp_in[i] = pix[i][15:8];
            edsw_pkg::CH_BLUE:  smp_in[i] = pix[i][7:0];
            default:            smp_in[i] = grey_prod[i][18:11];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      op_ff  <= edge_operator;
   end

   assign beat.valid = valid_ff;
   assign beat.op    = op_ff;
   assign beat.smp   = smp_ff;

endmodule

FILE: design/edsw_kernel.sv
// ----------------------------------------------------------------------------
// edsw_kernel: Sobel gradients, squares and Laplacian
// Three stages: kernel sums, squares and clamp, gradient energy sum.
// ----------------------------------------------------------------------------
module edsw_kernel (
   input  logic                      clock,
   input  logic                      reset,
   input  edsw_pkg::window_beat_type in_beat,
   output edsw_pkg::sqrt_beat_type   out_beat
);

   // stage A: kernel sums
   logic signed [10:0] gx_in, gx_ff;
   logic signed [10:0] gy_in, gy_ff;
   logic signed [11:0] lap_in, lap_ff;
   logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
   logic [10:0]        nb_sum;
   logic               a_valid_ff, a_op_ff;

   // stage B: squares, Laplacian clamp
   logic signed [21:0] sqx_full, sqy_full;
   logic [19:0]        sqx_ff, sqy_ff;
   logic [7:0]         lapc_in, lapc_ff;
   logic               b_valid_ff, b_op_ff;

   // stage C: energy sum
   logic [20:0]        energy;
   logic [15:0]        n_ff;
   logic               big_ff;
   logic [7:0]         lapc_c_ff;
   logic               c_valid_ff, c_op_ff;

   always_comb begin
      gx_pos = {2'b00, in_beat.smp[edsw_pkg::TAP_NE]} + {1'b0, in_beat.smp[edsw_pkg::TAP_E], 1'b0}
             + {2'b00, in_beat.smp[edsw_pkg::TAP_SE]};
      gx_neg = {2'b00, in_beat.smp[edsw_pkg::TAP_NW]} + {1'b0, in_beat.smp[edsw_pkg::TAP_W], 1'b0}
             + {2'b00, in_beat.smp[edsw_pkg::TAP_SW]};
      gy_pos = {2'b00, in_beat.smp[edsw_pkg::TAP_SW]} + {1'b0, in_beat.smp[edsw_pkg::TAP_S], 1'b0}
             + {2'b00, in_beat.smp[edsw_pkg::TAP_SE]};
      gy_neg = {2'b00, in_beat.smp[edsw_pkg::TAP_NW]} + {1'b0, in_beat.smp[edsw_pkg::TAP_N], 1'b0}
             + {2'b00, in_beat.smp[edsw_pkg::TAP_NE]};
      gx_in  = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy_in  = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
      nb_sum = 11'd0;
      for (int i = 0; i < edsw_pkg::NUM_TAPS; i++) begin
         if (i != edsw_pkg::TAP_CTR) begin
            nb_sum = nb_sum + {3'b000, in_beat.smp[i]};
         end
      end
      lap_in = $signed({1'b0, nb_sum})
             - $signed({1'b0, in_beat.smp[edsw_pkg::TAP_CTR], 3'b000});
   end

   // squares fit in 20 bits (|g| <= 1020)
   assign sqx_full = 22'(gx_ff) * 22'(gx_ff);
   assign sqy_full = 22'(gy_ff) * 22'(gy_ff);

   always_comb begin
      if (lap_ff < 0) begin
         lapc_in = 8'd0;
      end else if (lap_ff > 12'sd255) begin
         lapc_in = 8'd255;
      end else begin
         lapc_in = lap_ff[7:0];
      end
   end

   assign energy = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_beat.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      lap_ff    <= lap_in;
      a_op_ff   <= in_beat.op;
      sqx_ff    <= sqx_full[19:0];
      sqy_ff    <= sqy_full[19:0];
      lapc_ff   <= lapc_in;
      b_op_ff   <= a_op_ff;
      n_ff      <= energy[15:0];
      big_ff    <= |energy[20:16];
      lapc_c_ff <= lapc_ff;
      c_op_ff   <= b_op_ff;
   end

   assign out_beat.valid = c_valid_ff;
   assign out_beat.op    = c_op_ff;
   assign out_beat.big   = big_ff;
   assign out_beat.lap   = lapc_c_ff;
   assign out_beat.n     = n_ff;
   assign out_beat.rem   = 10'd0;
   assign out_beat.root  = 8'd0;

endmodule

FILE: design/edsw_isqrt.sv
// ----------------------------------------------------------------------------
// edsw_isqrt: pipelined integer square root of a 16-bit radicand
// Restoring digit recurrence, two root bits per register stage.
// ----------------------------------------------------------------------------
module edsw_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  edsw_pkg::sqrt_beat_type in_beat,
   output edsw_pkg::sqrt_beat_type out_beat
);

   edsw_pkg::sqrt_beat_type stage_in [edsw_pkg::SQRT_STAGES];
   edsw_pkg::sqrt_beat_type stage_ff [edsw_pkg::SQRT_STAGES];

   for (genvar k = 0; k < edsw_pkg::SQRT_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         always_comb begin
            stage_in[k] = edsw_pkg::sqrt_step(edsw_pkg::sqrt_step(in_beat));
         end
      end else begin : g_next
         always_comb begin
            stage_in[k] = edsw_pkg::sqrt_step(edsw_pkg::sqrt_step(stage_ff[k-1]));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k].valid <= stage_in[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k].op   <= stage_in[k].op;
         stage_ff[k].big  <= stage_in[k].big;
         stage_ff[k].lap  <= stage_in[k].lap;
         stage_ff[k].n    <= stage_in[k].n;
         stage_ff[k].rem  <= stage_in[k].rem;
         stage_ff[k].root <= stage_in[k].root;
      end
   end

   assign out_beat = stage_ff[edsw_pkg::SQRT_STAGES-1];

endmodule

FILE: design/edge_detect_3x3_window_core.sv
// ----------------------------------------------------------------------------
// edge_detect_3x3_window_core: 3x3 Sobel / Laplacian edge detector
// Reduces an RGB window to one channel and returns a clamped edge value.
// ----------------------------------------------------------------------------
// A window beat is taken on every cycle that start is high; busy never rises,
// so one window per clock is sustained indefinitely. Each beat comes back on
// rsp_edge_value with rsp_strobe high for one cycle, in order; the pipeline is
// fixed-latency and the result cannot be held off, so capture it on the strobe.
// The pipeline registers are channel extraction, kernel sums, gradient squares,
// energy sum, a 4-stage square root at two root bits per stage, and the output
// register. channel_select and edge_operator should only be written while no
// window is in flight.
// ----------------------------------------------------------------------------
module edge_detect_3x3_window_core (
   input  logic                          clock,
   input  logic                          reset,
   // window channel
   input  logic                          start,
   output logic                          busy,
   input  logic [23:0]                   req_pix_nw,
   input  logic [23:0]                   req_pix_n,
   input  logic [23:0]                   req_pix_ne,
   input  logic [23:0]                   req_pix_w,
   input  logic [23:0]                   req_pix_ctr,
   input  logic [23:0]                   req_pix_e,
   input  logic [23:0]                   req_pix_sw,
   input  logic [23:0]                   req_pix_s,
   input  logic [23:0]                   req_pix_se,
   // result channel
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_edge_value,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [edsw_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   // ---------------------------------------------------------------- CSRs
   logic [1:0] channel_select_ff;
   logic       edge_operator_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   // word index is paddr[2]; byte offset bits are don't-care
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= edsw_pkg::CH_GREY;
         edge_operator_ff  <= edsw_pkg::OP_SOBEL;
      end else if (csr_write) begin
         case (paddr[2])
            edsw_pkg::REG_CHANNEL_SELECT: channel_select_ff <= pwdata[1:0];
            edsw_pkg::REG_EDGE_OPERATOR:  edge_operator_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         edsw_pkg::REG_CHANNEL_SELECT: prdata = {30'd0, channel_select_ff};
         edsw_pkg::REG_EDGE_OPERATOR:  prdata = {31'd0, edge_operator_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------- datapath
   // no back-pressure anywhere: a beat enters every cycle start is high
   assign busy = 1'b0;

   logic                      req_accept;
   edsw_pkg::window_pix_type  pix_bus;
   edsw_pkg::window_beat_type win_beat;
   edsw_pkg::sqrt_beat_type   kern_beat;
   edsw_pkg::sqrt_beat_type   root_beat;

   assign req_accept = start & ~busy;

   assign pix_bus[edsw_pkg::TAP_NW]  = req_pix_nw;
   assign pix_bus[edsw_pkg::TAP_N]   = req_pix_n;
   assign pix_bus[edsw_pkg::TAP_NE]  = req_pix_ne;
   assign pix_bus[edsw_pkg::TAP_W]   = req_pix_w;
   assign pix_bus[edsw_pkg::TAP_CTR] = req_pix_ctr;
   assign pix_bus[edsw_pkg::TAP_E]   = req_pix_e;
   assign pix_bus[edsw_pkg::TAP_SW]  = req_pix_sw;
   assign pix_bus[edsw_pkg::TAP_S]   = req_pix_s;
   assign pix_bus[edsw_pkg::TAP_SE]  = req_pix_se;

   // stage 1: per-tap channel sample
   edsw_extract u_extract (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_accept),
      .channel_select (channel_select_ff),
      .edge_operator  (edge_operator_ff),
      .pix            (pix_bus),
      .beat           (win_beat)
   );

   // stages 2-4: gradients, squares, energy; Laplacian rides alongside
   edsw_kernel u_kernel (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (win_beat),
      .out_beat (kern_beat)
   );

   // stages 5-8: square root of the energy's low 16 bits
   edsw_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (kern_beat),
      .out_beat (root_beat)
   );

   // stage 9: operator select and Sobel saturation
   logic       rsp_strobe_ff;
   logic [7:0] edge_in, edge_ff;

   always_comb begin
      if (root_beat.op == edsw_pkg::OP_LAPLACE) begin
         edge_in = root_beat.lap;
      end else if (root_beat.big) begin
         edge_in = 8'd255;   // energy >= 65536 means root >= 256
      end else begin
         edge_in = root_beat.root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= root_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff <= edge_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_edge_value = edge_ff;

   // ---------------------------------------------------------- checks
   // every accepted window produces exactly one beat, a fixed latency later
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##(edsw_pkg::PIPE_LATENCY) rsp_strobe)
      else $error("accepted window produced no result beat");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, edsw_pkg::PIPE_LATENCY))
      else $error("result beat without an accepted window");

   // a pure Sobel beat below saturation must leave a remainder of at most twice its root
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (root_beat.valid && root_beat.op == edsw_pkg::OP_SOBEL && !root_beat.big)
      |-> ({1'b0, root_beat.rem} <= {root_beat.root, 1'b0}))
      else $error("square root remainder out of range");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for edge_detect_3x3_window_core
// Drives RGB window beats through the command channel, programs the channel
// and operator registers over the APB port between phases, and scores each
// strobed edge value against a pinned value or an in-bench Sobel / Laplacian predictor.
// ----------------------------------------------------------------------------
module testbench;
   import edsw_pkg::*;

   // run limit in clocks
   localparam int CYCLE_LIMIT   = 400000;
   localparam int BEATS_PER_SET = 160;

   // one directed row: register setting, window, and an optional pinned result
   typedef struct packed {
      logic [1:0]     ch;
      logic           op;
      window_pix_type win;
      int             pin;    // -1: score against the predictor
   } window_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [23:0] req_pix_nw, req_pix_n, req_pix_ne;
   logic [23:0] req_pix_w, req_pix_ctr, req_pix_e;
   logic [23:0] req_pix_sw, req_pix_s, req_pix_se;
   logic        rsp_strobe;
   logic [7:0]  rsp_edge_value;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // bench copy of the two registers, updated when the write is taken
   logic [1:0]  chan_shadow;
   logic        op_shadow;

   // pinned value for the beat on the bus, -1 when the predictor decides
   int          pin_now;
   logic [7:0]  expected_edges[$];
   window_row_type directed_rows[$];
   int          fault_count;
   int          cycle_count;

   edge_detect_3x3_window_core uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pix_nw     (req_pix_nw),
      .req_pix_n      (req_pix_n),
      .req_pix_ne     (req_pix_ne),
      .req_pix_w      (req_pix_w),
      .req_pix_ctr    (req_pix_ctr),
      .req_pix_e      (req_pix_e),
      .req_pix_sw     (req_pix_sw),
      .req_pix_s      (req_pix_s),
      .req_pix_se     (req_pix_se),
      .rsp_strobe     (rsp_strobe),
      .rsp_edge_value (rsp_edge_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // one 8-bit sample of the selected channel; grey truncates the mean
   function automatic int channel_sample(logic [23:0] px, logic [1:0] ch);
      int r;
      int g;
      int b;
      r = px[23:16];
      g = px[15:8];
      b = px[7:0];
      case (ch)
         CH_RED:   return r;
         CH_GREEN: return g;
         CH_BLUE:  return b;
         default:  return (r + g + b) / 3;
      endcase
   endfunction

   function automatic logic [7:0] edge_predict(window_pix_type win, logic [1:0] ch,
                                               logic op);
      int          s[NUM_TAPS];
      int          gx;
      int          gy;
      int          resp;
      int unsigned energy;
      int unsigned root;
      int unsigned trial;
      for (int i = 0; i < NUM_TAPS; i++)
         s[i] = channel_sample(win[i], ch);
      if (op == OP_SOBEL) begin
         gx = (s[TAP_NE] + 2 * s[TAP_E] + s[TAP_SE])
            - (s[TAP_NW] + 2 * s[TAP_W] + s[TAP_SW]);
         gy = (s[TAP_SW] + 2 * s[TAP_S] + s[TAP_SE])
            - (s[TAP_NW] + 2 * s[TAP_N] + s[TAP_NE]);
         energy = gx * gx + gy * gy;
         // greedy bit-by-bit floor root; energy < 2^22 so 11 root bits suffice
         root = 0;
         for (int k = 11; k >= 0; k--) begin
            trial = root | (32'd1 << k);
            if (trial * trial <= energy)
               root = trial;
         end
         resp = root;
      end else begin
         resp = s[TAP_NW] + s[TAP_N] + s[TAP_NE] + s[TAP_W] + s[TAP_E]
              + s[TAP_SW] + s[TAP_S] + s[TAP_SE] - 8 * s[TAP_CTR];
      end
      if (resp < 0)
         return 8'd0;
      if (resp > 255)
         return 8'd255;
      return resp[7:0];
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: beats taken on start & !busy, results taken on the strobe
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [7:0]     want;
      window_pix_type win;
      if (!reset) begin
         if (start && !busy) begin
            win[TAP_NW]  = req_pix_nw;
            win[TAP_N]   = req_pix_n;
            win[TAP_NE]  = req_pix_ne;
            win[TAP_W]   = req_pix_w;
            win[TAP_CTR] = req_pix_ctr;
            win[TAP_E]   = req_pix_e;
            win[TAP_SW]  = req_pix_sw;
            win[TAP_S]   = req_pix_s;
            win[TAP_SE]  = req_pix_se;
            if (pin_now >= 0)
               expected_edges.push_back(pin_now[7:0]);
            else
               expected_edges.push_back(edge_predict(win, chan_shadow, op_shadow));
         end
         if (rsp_strobe) begin
            if (expected_edges.size() == 0) begin
               $display("%0t: unexpected edge beat: expected none, actual %0d",
                        $time, rsp_edge_value);
               fault_count++;
            end else begin
               want = expected_edges.pop_front();
               if (rsp_edge_value !== want) begin
                  $display("%0t: edge_value mismatch: expected %0d, actual %0d",
                           $time, want, rsp_edge_value);
                  fault_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("edge_detect_3x3_window_core: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers: everything changes on the falling edge
   // ---------------------------------------------------------------------

   // APB write: setup, access, taken when pready is seen high
   task automatic reg_write(logic reg_idx, logic [31:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {reg_idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_idx == REG_CHANNEL_SELECT)
         chan_shadow = data[1:0];
      else
         op_shadow = data[0];
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // APB read, checked against the shadow copy
   task automatic reg_read_check(logic reg_idx);
      logic [31:0] want;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {reg_idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      want = (reg_idx == REG_CHANNEL_SELECT) ? {30'd0, chan_shadow} : {31'd0, op_shadow};
      if (prdata !== want) begin
         $display("%0t: register %0d readback mismatch: expected %0d, actual %0d",
                  $time, reg_idx, want, prdata);
         fault_count++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Junk in the unused upper bits checks that the block masks them.
   task automatic set_mode(logic [1:0] ch, logic op);
      reg_write(REG_CHANNEL_SELECT, ($urandom & ~32'h3) | {30'd0, ch});
      reg_write(REG_EDGE_OPERATOR,  ($urandom & ~32'h1) | {31'd0, op});
      reg_read_check(REG_CHANNEL_SELECT);
      reg_read_check(REG_EDGE_OPERATOR);
   endtask

   // present one window beat and hold it until it is taken
   task automatic send_window(window_pix_type win, int pin);
      @(negedge clock);
      start       = 1'b1;
      req_pix_nw  = win[TAP_NW];
      req_pix_n   = win[TAP_N];
      req_pix_ne  = win[TAP_NE];
      req_pix_w   = win[TAP_W];
      req_pix_ctr = win[TAP_CTR];
      req_pix_e   = win[TAP_E];
      req_pix_sw  = win[TAP_SW];
      req_pix_s   = win[TAP_S];
      req_pix_se  = win[TAP_SE];
      pin_now     = pin;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      start = 1'b0;
   endtask

   // stop sending and wait for every outstanding edge beat
   task automatic drain();
      idle_cycle();
      while (expected_edges.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_row(logic [1:0] ch, logic op,
                          logic [23:0] nw, logic [23:0] n, logic [23:0] ne,
                          logic [23:0] w, logic [23:0] ctr, logic [23:0] e,
                          logic [23:0] sw, logic [23:0] s, logic [23:0] se, int pin);
      window_row_type row;
      row.ch            = ch;
      row.op            = op;
      row.win[TAP_NW]   = nw;
      row.win[TAP_N]    = n;
      row.win[TAP_NE]   = ne;
      row.win[TAP_W]    = w;
      row.win[TAP_CTR]  = ctr;
      row.win[TAP_E]    = e;
      row.win[TAP_SW]   = sw;
      row.win[TAP_S]    = s;
      row.win[TAP_SE]   = se;
      row.pin           = pin;
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] near_byte(int base, int spread);
      return 8'(base + $urandom_range(0, spread));
   endfunction

   // Random windows. Fully random pixels mostly saturate Sobel, so most
   // windows are smooth patches that land in the mid range of the root.
   function automatic window_pix_type random_window();
      window_pix_type win;
      int style;
      int spread;
      int br;
      int bg;
      int bb;
      int odd_tap;
      style = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
         0:       spread = 2;
         1:       spread = 12;
         default: spread = 60;
      endcase
      br = $urandom_range(0, 255 - spread);
      bg = $urandom_range(0, 255 - spread);
      bb = $urandom_range(0, 255 - spread);
      odd_tap = $urandom_range(0, NUM_TAPS - 1);
      for (int i = 0; i < NUM_TAPS; i++) begin
         if (style < 30)
            win[i] = $urandom;
         else if (style < 75)
            win[i] = {near_byte(br, spread), near_byte(bg, spread), near_byte(bb, spread)};
         else if (style < 88)
            // flat patch with one odd pixel
            win[i] = (i == odd_tap) ? 24'($urandom) : {8'(br), 8'(bg), 8'(bb)};
         else
            // hard black / white / primary edges
            case ($urandom_range(0, 3))
               0:       win[i] = 24'h000000;
               1:       win[i] = 24'hFFFFFF;
               2:       win[i] = 24'hFF << (8 * $urandom_range(0, 2));
               default: win[i] = $urandom;
            endcase
      end
      return win;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [1:0] set_ch[8];
      logic       set_op[8];
      int         idle_pct;
      window_row_type row;

      reset       = 1'b1;
      start       = 1'b0;
      req_pix_nw  = '0;
      req_pix_n   = '0;
      req_pix_ne  = '0;
      req_pix_w   = '0;
      req_pix_ctr = '0;
      req_pix_e   = '0;
      req_pix_sw  = '0;
      req_pix_s   = '0;
      req_pix_se  = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      pin_now     = -1;
      chan_shadow = CH_GREY;
      op_shadow   = OP_SOBEL;
      fault_count = 0;
      cycle_count = 0;

      // Directed table. First rows run on the reset setting, no write yet.
      // grey Sobel: flat black, flat white, full-scale vertical edge
      add_row(CH_GREY, OP_SOBEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(CH_GREY, OP_SOBEL, '1, '1, '1, '1, '1, '1, '1, '1, '1, 0);
      add_row(CH_GREY, OP_SOBEL, 0, 24'h808080, '1, 0, 24'h808080, '1,
              0, 24'h808080, '1, 255);
      // grey truncation: 2/3 -> 0, 3/3 -> 1
      add_row(CH_GREY, OP_SOBEL, 0, 0, 0, 0, 0, 24'h000002, 0, 0, 0, 0);
      add_row(CH_GREY, OP_SOBEL, 0, 0, 0, 0, 0, 24'h010101, 0, 0, 0, 2);
      add_row(CH_GREY, OP_SOBEL, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, -1);
      // red Sobel: 6/8/10 triangle, other channels ignored, root near 255/256
      add_row(CH_RED, OP_SOBEL, 0, 0, 0, 0, 0, 24'h030000, 0, 24'h040000, 0, 10);
      add_row(CH_RED, OP_SOBEL, 24'h00FFFF, 0, 24'h00FFFF, 0, 24'h00FFFF, 24'h00FFFF,
              0, 24'h00FFFF, 0, 0);
      add_row(CH_RED, OP_SOBEL, 0, 0, 24'h010000, 0, 0, 24'h7F0000, 0, 0, 0, -1);
      add_row(CH_RED, OP_SOBEL, 0, 0, 0, 0, 0, 24'h800000, 0, 0, 0, 255);
      // green Laplacian: negative clamps to 0, full positive to 255
      add_row(CH_GREEN, OP_LAPLACE, 0, 0, 0, 0, 24'h00FF00, 0, 0, 0, 0, 0);
      add_row(CH_GREEN, OP_LAPLACE, 24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00, 0,
              24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00, 255);
      add_row(CH_GREEN, OP_LAPLACE, 0, 24'h000100, 0, 0, 0, 0, 0, 0, 0, 1);
      add_row(CH_GREEN, OP_LAPLACE, 24'h123456, 24'h123456, 24'h123456, 24'h123456,
              24'h123456, 24'h123456, 24'h123456, 24'h123456, 24'h123456, 0);
      add_row(CH_GREEN, OP_LAPLACE, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, -1);
      // blue Laplacian
      add_row(CH_BLUE, OP_LAPLACE, '1, '1, '1, '1, 24'hFFFF00, '1, '1, '1, '1, 255);
      add_row(CH_BLUE, OP_LAPLACE, 0, 0, 0, 0, 0, 0, 0, 0, 24'h0000FE, 254);
      // grey Laplacian: white corner, blue-only corner, truncated to 0
      add_row(CH_GREY, OP_LAPLACE, '1, 0, 0, 0, 0, 0, 0, 0, 0, 255);
      add_row(CH_GREY, OP_LAPLACE, 24'h0000FF, 0, 0, 0, 0, 0, 0, 0, 0, 85);
      add_row(CH_GREY, OP_LAPLACE, 24'h000002, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // blue Sobel: diagonal corner saturates
      add_row(CH_BLUE, OP_SOBEL, 24'hFFFF00, 24'hFFFF00, 24'h0000FF, 24'hFFFF00,
              24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 255);
      add_row(CH_BLUE, OP_SOBEL, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, -1);
      add_row(CH_BLUE, OP_SOBEL, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, -1);

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed walk: back-to-back within a setting, drain before each write
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.ch != chan_shadow || row.op != op_shadow) begin
            drain();
            set_mode(row.ch, row.op);
         end
         send_window(row.win, row.pin);
      end
      drain();

      // random phases over every setting, extremes first; sender idling
      // cycles through none / 62% / none / 13% with idle-free stretches
      set_ch = '{CH_GREY, CH_BLUE, CH_RED, CH_GREEN, CH_BLUE, CH_GREY, CH_RED, CH_GREEN};
      set_op = '{OP_SOBEL, OP_LAPLACE, OP_SOBEL, OP_LAPLACE,
                 OP_SOBEL, OP_LAPLACE, OP_LAPLACE, OP_SOBEL};
      for (int p = 0; p < 8; p++) begin
         set_mode(set_ch[p], set_op[p]);
         case (p % 4)
            1:       idle_pct = 62;
            3:       idle_pct = 13;
            default: idle_pct = 0;
         endcase
         for (int k = 0; k < BEATS_PER_SET; k++) begin
            // mid-phase hold-off until the pipe is empty
            if (k == BEATS_PER_SET / 2)
               drain();
            if ((k % 50) >= 15)
               while ($urandom_range(0, 99) < idle_pct)
                  idle_cycle();
            send_window(random_window(), -1);
         end
         drain();
      end

      // let any stray strobe show up before the verdict
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (expected_edges.size() != 0) begin
         $display("%0t: %0d edge beats never arrived", $time, expected_edges.size());
         fault_count++;
      end
      if (fault_count == 0)
         $display("edge_detect_3x3_window_core: match");
      else
         $display("edge_detect_3x3_window_core: mismatch");
      $finish;
   end

endmodule
